>>> design/hlfr_pkg.sv
// Shared constants and types for the header/length frame receiver.
// No dependencies; the parser, copy-out unit and top level refer to this package by scoped names.
`default_nettype none

package hlfr_pkg;

    // Frame store geometry and copy-out length.
    localparam int BUF_DEPTH = 32;
    localparam int COPY_LEN  = 9;

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
    localparam int KW     = (COPY_LEN > 1) ? $clog2(COPY_LEN) : 1;
    localparam int LEN_W  = 9;
    localparam int IDX_W  = 5;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE       = 8'h5A;
    localparam logic [BYTE_W-1:0] ACCEPT_CODE_RST = 8'h15;
    localparam logic [LEN_W-1:0]  FRAME_OVERHEAD  = 9'd5;

    // Input item kinds carried on the slave-side tuser.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Write request into the frame store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    // Read request from the copy-out unit.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

`default_nettype wire

>>> design/hlfr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module hlfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/hlfr_parser.sv
// Frame parser: byte position counter, header shadow registers, ready flag and capture decision.
// Depends on hlfr_pkg.
`default_nettype none

module hlfr_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            op,
    input  wire logic [hlfr_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic [hlfr_pkg::BYTE_W-1:0]     accept_code,
    output hlfr_pkg::store_wr_t                  wr,
    output logic                                 capture
);

    logic [hlfr_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic [hlfr_pkg::BYTE_W-1:0] func_reg;
    logic [hlfr_pkg::BYTE_W-1:0] len_reg;
    logic                        flag_reg, flag_next;

    logic                        byte_req;
    logic [hlfr_pkg::CNT_W-1:0]  cnt_inc;
    logic [hlfr_pkg::LEN_W-1:0]  cnt_cmp;
    logic [hlfr_pkg::BYTE_W-1:0] len_byte;
    logic [hlfr_pkg::LEN_W-1:0]  need;
    logic                        sync_bad;
    logic                        past_hdr;
    logic                        complete;
    logic                        overflow;

    assign byte_req = accept && (op == hlfr_pkg::OP_BYTE);
    assign cnt_inc  = hlfr_pkg::CNT_W'(cnt_reg) + hlfr_pkg::CNT_W'(1);
    assign cnt_cmp  = hlfr_pkg::LEN_W'(cnt_inc);
    assign len_byte = (cnt_reg == hlfr_pkg::ADDR_W'(3)) ? rx_byte : len_reg;
    assign need     = hlfr_pkg::LEN_W'(len_byte) + hlfr_pkg::FRAME_OVERHEAD;

    // Both sync positions must hold the sync byte; otherwise the frame restarts.
    assign sync_bad = ((cnt_reg == hlfr_pkg::ADDR_W'(0)) || (cnt_reg == hlfr_pkg::ADDR_W'(1)))
                      && (rx_byte != hlfr_pkg::SYNC_BYTE);
    assign past_hdr = cnt_cmp > hlfr_pkg::LEN_W'(3);
    assign complete = past_hdr && (cnt_cmp == need);
    assign overflow = past_hdr && (cnt_cmp >= hlfr_pkg::LEN_W'(hlfr_pkg::BUF_DEPTH));

    assign capture  = byte_req && !sync_bad && complete && (func_reg == accept_code) && !flag_reg;

    assign wr.en   = byte_req;
    assign wr.addr = cnt_reg;
    assign wr.data = rx_byte;

    always_comb
    begin
        cnt_next  = cnt_reg;
        flag_next = flag_reg;
        if (accept && (op == hlfr_pkg::OP_RELEASE))
        begin
            flag_next = 1'b0;
        end
        else if (byte_req)
        begin
            if (sync_bad || complete || overflow)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_inc[hlfr_pkg::ADDR_W-1:0];
            end
            if (capture)
            begin
                flag_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            flag_reg <= flag_next;
        end
    end

    // Function and length bytes are shadowed so completion needs no extra store read.
    always_ff @(posedge clk)
    begin
        if (byte_req && (cnt_reg == hlfr_pkg::ADDR_W'(2)))
        begin
            func_reg <= rx_byte;
        end
        if (byte_req && (cnt_reg == hlfr_pkg::ADDR_W'(3)))
        begin
            len_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> design/hlfr_reader.sv
// Copy-out unit: reads the first positions of the frame store and drives the output register.
// Depends on hlfr_pkg.
`default_nettype none

module hlfr_reader (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [hlfr_pkg::BYTE_W-1:0]  rd_data,
    output hlfr_pkg::store_rd_t               rd,
    output logic                              busy,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [hlfr_pkg::BYTE_W-1:0]       out_byte,
    output logic [hlfr_pkg::IDX_W-1:0]        out_index,
    output logic                              out_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COPY = 1'b1;

    logic                   state_reg, state_next;
    logic [hlfr_pkg::KW-1:0] k_reg, k_next;
    logic                   pend_reg;
    logic                   pend_zero_reg;
    logic [hlfr_pkg::KW-1:0] pend_k_reg;
    logic                   valid_reg;
    logic                   issue;
    logic                   k_in_store;
    logic                   k_final;

    assign k_in_store = int'(k_reg) < hlfr_pkg::BUF_DEPTH;
    assign k_final    = k_reg == hlfr_pkg::KW'(hlfr_pkg::COPY_LEN - 1);

    // One read in flight; the output register is free by the time its data returns.
    assign issue   = (state_reg == ST_COPY) && !pend_reg && (!valid_reg || out_ready);
    assign rd.en   = issue && k_in_store;
    assign rd.addr = hlfr_pkg::ADDR_W'(k_reg);

    assign busy      = (state_reg == ST_COPY) || pend_reg;
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_COPY;
                    k_next     = '0;
                end
            end
            ST_COPY:
            begin
                if (issue)
                begin
                    if (k_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + hlfr_pkg::KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            pend_reg  <= issue;
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_k_reg    <= k_reg;
            pend_zero_reg <= !k_in_store;
        end
        if (pend_reg)
        begin
            out_byte  <= pend_zero_reg ? '0 : rd_data;
            out_index <= hlfr_pkg::IDX_W'(pend_k_reg);
            out_last  <= pend_k_reg == hlfr_pkg::KW'(hlfr_pkg::COPY_LEN - 1);
        end
    end

endmodule

`default_nettype wire

>>> design/header_length_frame_receiver.sv
// Top level of the header/length frame receiver: frame store RAM with per-entry valid bits,
// parser, copy-out unit and the configuration register. Depends on hlfr_pkg and its submodules.
//
//  Channel   Direction  Signals                         Contents
//  s_axis    in         s_tvalid/s_tready/s_tdata/user  tdata: rx_byte; tuser: op
//  m_axis    out        m_tvalid/m_tready/m_tdata/last  tdata: out_byte, out_index; tlast: last
//  cfg       in         cfg_valid/cfg_ready/cfg_data    accept_code
//
// A received byte is written to the frame store in the cycle it is taken; a release request
// only clears the ready flag. A byte that completes a captured frame starts the copy-out,
// which moves each emitted byte by a store read and then the output register, issuing the
// next read only once the previous one has returned. The input is held off from the capture
// until the data of the last read has come back.
// The output register is stalled by m_tready; no request is lost or repeated.
// Reset clears the position counter, ready flag and valid bits, sets accept_code to 0x15; store
// entries that were never written read as zero through the valid bits, so no clearing pass runs.
`default_nettype none

module header_length_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] op: 0 = received byte, 1 = release ready flag

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [12:8] out_index, [15:13] zero
    output logic             m_tlast,   // last byte of the captured run

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // [7:0] accept_code
);

    logic [hlfr_pkg::BYTE_W-1:0]    accept_code_reg;
    logic [hlfr_pkg::BUF_DEPTH-1:0] written_reg;
    logic                           rd_written_reg;

    hlfr_pkg::store_wr_t            wr;
    hlfr_pkg::store_rd_t            rd;
    logic [hlfr_pkg::BYTE_W-1:0]    ram_rdata;
    logic [hlfr_pkg::BYTE_W-1:0]    rd_data;
    logic                           s_accept;
    logic                           capture;
    logic                           reader_busy;
    logic [hlfr_pkg::BYTE_W-1:0]    out_byte;
    logic [hlfr_pkg::IDX_W-1:0]     out_index;

    // The parser only runs while the copy-out unit has no read left to issue, so a store
    // write and a copy-out read never address the store in the same cycle.
    assign s_tready  = !reader_busy;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_code_reg <= hlfr_pkg::ACCEPT_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            accept_code_reg <= cfg_data;
        end
    end

    hlfr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .op          (s_tuser[0]),
        .rx_byte     (s_tdata),
        .accept_code (accept_code_reg),
        .wr          (wr),
        .capture     (capture)
    );

    hlfr_ram #(
        .WIDTH (hlfr_pkg::BYTE_W),
        .DEPTH (hlfr_pkg::BUF_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (ram_rdata)
    );

    // The store is not reset; an entry not yet written since reset reads as zero via its valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_written_reg <= written_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? ram_rdata : '0;

    hlfr_reader u_reader (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (capture),
        .rd_data   (rd_data),
        .rd        (rd),
        .busy      (reader_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, out_index, out_byte};

endmodule

`default_nettype wire

>>> sim/hlfr_checker.sv
// Scoreboard for the header/length frame receiver: watches the input, configuration and output
// channels, predicts the copied frame bytes and compares them. Depends on hlfr_pkg only.
`default_nettype none

module hlfr_checker
    import hlfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] op

    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] out_byte, [12:8] out_index, [15:13] zero
    input  wire logic        m_tlast,   // last

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,  // [7:0] accept_code

    output int               mismatches,
    output int               bytes_due,
    output int               requests_seen,
    output int               bytes_checked,
    output int               captures,
    output int               busy_drops,
    output int               overlong_drops
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  pos;
        logic              last;
    } copy_byte_t;

    // Private copy of the receiver state.
    logic [BYTE_W-1:0] store_copy [BUF_DEPTH];
    int unsigned       fill;
    logic              flag_copy;
    logic [BYTE_W-1:0] code_copy;
    copy_byte_t        copy_due_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Stores one received byte and queues the copy-out bytes of a captured frame it completes.
    task automatic predict_capture(input logic [BYTE_W-1:0] rx);
        int unsigned need;
        int          k;
        copy_byte_t  cb;
        if (fill >= BUF_DEPTH)
            fill = 0;
        store_copy[fill] = rx;
        fill++;
        if (store_copy[0] != SYNC_BYTE)
            fill = 0;
        if (fill == 2 && store_copy[1] != SYNC_BYTE)
            fill = 0;
        if (fill > 3)
        begin
            need = store_copy[3] + FRAME_OVERHEAD;
            if (fill == need)
            begin
                if (store_copy[2] == code_copy && !flag_copy)
                begin
                    for (k = 0; k < COPY_LEN; k++)
                    begin
                        cb.data = (k < BUF_DEPTH) ? store_copy[k] : '0;
                        cb.pos  = k[IDX_W-1:0];
                        cb.last = (k == COPY_LEN - 1);
                        copy_due_q.push_back(cb);
                    end
                    flag_copy = 1'b1;
                    captures++;
                end
                else if (store_copy[2] == code_copy)
                begin
                    busy_drops++;
                end
                fill = 0;
            end
            else if (fill >= BUF_DEPTH)
            begin
                fill = 0;
                overlong_drops++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int         i;
        copy_byte_t want;
        if (!rst_n)
        begin
            for (i = 0; i < BUF_DEPTH; i++)
                store_copy[i] = '0;
            fill      = 0;
            flag_copy = 1'b0;
            code_copy = ACCEPT_CODE_RST;
            copy_due_q.delete();
            bytes_due = 0;
        end
        else
        begin
            // Outputs first: a result can never stem from a request taken at the same edge.
            if (m_tvalid && m_tready)
            begin
                bytes_checked++;
                if (copy_due_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end
                else
                begin
                    want = copy_due_q.pop_front();
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("out_byte", m_tdata[7:0], want.data);
                    if (m_tdata[12:8] != want.pos)
                        report_mismatch("out_index", m_tdata[12:8], want.pos);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                    if (m_tdata[15:13] != 3'b000)
                        report_mismatch("tdata pad bits", m_tdata[15:13], 0);
                end
            end
            if (cfg_valid && cfg_ready)
                code_copy = cfg_data;
            if (s_tvalid && s_tready)
            begin
                requests_seen++;
                if (s_tuser[0] == OP_RELEASE)
                    flag_copy = 1'b0;
                else
                    predict_capture(s_tdata);
            end
            bytes_due = copy_due_q.size();
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_header_length_frame_receiver.sv
// Testbench top for the header/length frame receiver: clock, reset, stimulus and verdict.
// Depends on hlfr_pkg, the receiver RTL and the hlfr_checker scoreboard in this folder.
`default_nettype none

module tb_header_length_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import hlfr_pkg::*;

    // Longest quiet stretch tolerated; it lies well above HOLD_CYCLES, the long receiver hold.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    // This pause lets the copy-out of a capture finish, with margin.
    localparam int DRAIN_CYCLES   = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]  s_tuser   = '0;   // [0] op

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_byte, [12:8] out_index, [15:13] zero
    logic        m_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;   // [7:0] accept_code

    // Idling mix of the current phase, in percent of cycles.
    int          sender_idle_pct = 0;
    int          stall_pct       = 0;

    // Long receiver hold: a one-cycle pulse from the stimulus starts a counted hold.
    logic        hold_start = 1'b0;
    int          hold_left  = 0;

    int          quiet_cycles = 0;
    int          items_sent   = 0;
    logic [7:0]  active_code  = ACCEPT_CODE_RST;

    int          mismatches;
    int          bytes_due;
    int          requests_seen;
    int          bytes_checked;
    int          captures;
    int          busy_drops;
    int          overlong_drops;

    header_length_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    hlfr_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .bytes_due      (bytes_due),
        .requests_seen  (requests_seen),
        .bytes_checked  (bytes_checked),
        .captures       (captures),
        .busy_drops     (busy_drops),
        .overlong_drops (overlong_drops)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Output side: random back-pressure at the phase's rate, or a counted long hold.
    // The hold is what lets the copy-out back up until the block refuses input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_start)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d result bytes still due.",
                     quiet_cycles, bytes_due);
            $display("[header_length_frame_receiver] ERROR");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is taken. The valid line is only
    // lowered when an idle cycle is inserted, so back-to-back requests keep it high.
    task automatic push_request(input logic op, input logic [7:0] rx);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= rx;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // A well-formed frame: two sync bytes, function, length, payload, unchecked checksum.
    task automatic send_frame(input logic [7:0] func, input logic [7:0] len);
        int          n;
        logic [7:0]  rnd;
        push_request(OP_BYTE, SYNC_BYTE);
        push_request(OP_BYTE, SYNC_BYTE);
        push_request(OP_BYTE, func);
        push_request(OP_BYTE, len);
        for (n = 0; n < len; n++)
        begin
            rnd = 8'($urandom_range(255));
            push_request(OP_BYTE, rnd);
        end
        rnd = 8'($urandom_range(255));
        push_request(OP_BYTE, rnd);
    endtask

    // Writes accept_code only once the block is idle: all copied bytes are out and the
    // copy-out has had time to finish.
    task automatic configure_when_idle(input logic [7:0] code);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        active_code = code;
    endtask

    // Mostly complete frames with random content, mixed with releases, line noise and
    // broken headers. Lengths stay short; a few reach the store limit or overflow it.
    task automatic send_random_traffic(input int count);
        int          target;
        int          kind;
        int          pick;
        logic [7:0]  func;
        logic [7:0]  len;
        logic [7:0]  rnd;
        target = items_sent + count;
        while (items_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                func = ($urandom_range(99) < 80) ? active_code : 8'($urandom_range(255));
                pick = $urandom_range(99);
                if (pick < 75)
                    len = 8'($urandom_range(6));
                else if (pick < 92)
                    len = 8'($urandom_range(27, 7));
                else
                    len = 8'($urandom_range(40, 28));
                send_frame(func, len);
                if ($urandom_range(1) == 1)
                begin
                    rnd = 8'($urandom_range(255));
                    push_request(OP_RELEASE, rnd);
                end
            end
            else if (kind < 68)
            begin
                rnd = 8'($urandom_range(255));
                push_request(OP_RELEASE, rnd);
            end
            else if (kind < 84)
            begin
                rnd = ($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom_range(255));
                push_request(OP_BYTE, rnd);
            end
            else
            begin
                // Broken header: a bad second sync byte, or a header cut short so that
                // whatever follows is taken as its payload.
                push_request(OP_BYTE, SYNC_BYTE);
                if ($urandom_range(1) == 1)
                begin
                    rnd = 8'($urandom_range(255));
                    push_request(OP_BYTE, rnd);
                end
                else
                begin
                    push_request(OP_BYTE, SYNC_BYTE);
                    push_request(OP_BYTE, active_code);
                    rnd = 8'($urandom_range(255));
                    push_request(OP_BYTE, rnd);
                end
            end
        end
    endtask

    initial
    begin
        logic [7:0] code;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 0, reset accept code, no idling. Directed requests first.
        // Release while the flag is already clear, with an all-ones byte that must be ignored.
        push_request(OP_RELEASE, 8'hFF);
        // A zero byte where a sync byte belongs, then a bad second sync byte.
        push_request(OP_BYTE, 8'h00);
        push_request(OP_BYTE, SYNC_BYTE);
        push_request(OP_BYTE, 8'hFF);
        // Shortest frame, matching code: captured, and the copy runs past it into
        // store entries that were never written this run.
        push_request(OP_BYTE, SYNC_BYTE);
        push_request(OP_BYTE, SYNC_BYTE);
        push_request(OP_BYTE, ACCEPT_CODE_RST);
        push_request(OP_BYTE, 8'h00);
        push_request(OP_BYTE, 8'hFF);
        // Matching frame while the flag is still set: dropped without a result.
        send_frame(ACCEPT_CODE_RST, 8'd1);
        // Release with a zero byte, then a frame whose copy shows a byte left from the
        // dropped frame beyond its own end.
        push_request(OP_RELEASE, 8'h00);
        send_frame(ACCEPT_CODE_RST, 8'd0);

        // Long receiver hold while the sender keeps going: a capture backs up the
        // copy-out and the block stops taking requests. An overlong frame follows.
        push_request(OP_RELEASE, 8'h5A);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        send_frame(ACCEPT_CODE_RST, 8'd2);
        send_frame(ACCEPT_CODE_RST, 8'd28);
        push_request(OP_RELEASE, 8'hA5);
        send_random_traffic(80);

        // Phase 1: lowest accept code, sender idle most of the time.
        configure_when_idle(8'h00);
        sender_idle_pct = 62;
        stall_pct       = 0;
        send_random_traffic(90);

        // Phase 2: highest accept code, receiver stalling most of the time.
        configure_when_idle(8'hFF);
        sender_idle_pct = 0;
        stall_pct       = 62;
        send_random_traffic(90);

        // Phase 3: random accept code, light idling on both sides.
        code = 8'($urandom_range(255));
        configure_when_idle(code);
        sender_idle_pct = 17;
        stall_pct       = 17;
        send_random_traffic(90);

        // Phase 4: back to the reset code, full rate.
        configure_when_idle(ACCEPT_CODE_RST);
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_random_traffic(60);

        // Drain: wait for every predicted byte, then let the copy-out settle.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over five accept-code phases and four idling mixes.",
                 requests_seen);
        $display("%0d frames captured, %0d refused while busy, %0d overlong dropped.",
                 captures, busy_drops, overlong_drops);
        $display("%0d result bytes checked.", bytes_checked);
        if (mismatches == 0)
            $display("[header_length_frame_receiver] OK");
        else
            $display("[header_length_frame_receiver] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
